@@ rtl/core/sbt_pkg.sv @@
// ----------------------------------------------------------------------------
// sbt_pkg
// Shared types, constants and character-class helpers of the source byte
// tokenizer.
// ----------------------------------------------------------------------------
package sbt_pkg;

  localparam int unsigned PosBits  = 16;
  localparam int unsigned LenBits  = 16;
  localparam int unsigned ByteBits = 8;
  localparam int unsigned KindBits = 4;
  localparam int unsigned MaxToks  = 3;

  localparam logic [PosBits-1:0] PosMax = '1;

  localparam logic [ByteBits-1:0] CH_NUL    = 8'h00;
  localparam logic [ByteBits-1:0] CH_LPAREN = 8'h28;
  localparam logic [ByteBits-1:0] CH_RPAREN = 8'h29;
  localparam logic [ByteBits-1:0] CH_SEMI   = 8'h3B;
  localparam logic [ByteBits-1:0] CH_EQUALS = 8'h3D;
  localparam logic [ByteBits-1:0] CH_COLON  = 8'h3A;
  localparam logic [ByteBits-1:0] CH_QUOTE  = 8'h22;
  localparam logic [ByteBits-1:0] CH_DOT    = 8'h2E;
  localparam logic [ByteBits-1:0] CH_UNDER  = 8'h5F;
  localparam logic [ByteBits-1:0] CH_SPACE  = 8'h20;
  localparam logic [ByteBits-1:0] CH_TAB    = 8'h09;
  localparam logic [ByteBits-1:0] CH_CR     = 8'h0D;
  localparam logic [ByteBits-1:0] CH_ZERO   = 8'h30;
  localparam logic [ByteBits-1:0] CH_NINE   = 8'h39;
  localparam logic [ByteBits-1:0] CH_LC_A   = 8'h61;
  localparam logic [ByteBits-1:0] CH_LC_Z   = 8'h7A;
  localparam logic [ByteBits-1:0] CH_UC_A   = 8'h41;
  localparam logic [ByteBits-1:0] CH_UC_Z   = 8'h5A;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_STR    = 3'd1,
    MODE_INT    = 3'd2,
    MODE_INTDOT = 3'd3,
    MODE_FLOAT  = 3'd4,
    MODE_IDENT  = 3'd5
  } lex_mode_e;

  typedef enum logic [KindBits-1:0] {
    TK_END    = 4'd0,
    TK_LPAREN = 4'd1,
    TK_RPAREN = 4'd2,
    TK_SEMI   = 4'd3,
    TK_EQUALS = 4'd4,
    TK_COLON  = 4'd5,
    TK_STRING = 4'd6,
    TK_INT    = 4'd7,
    TK_FLOAT  = 4'd8,
    TK_IDENT  = 4'd9
  } token_kind_e;

  typedef struct packed {
    token_kind_e        kind;
    logic [LenBits-1:0] start;
    logic [LenBits-1:0] length;
  } token_t;

  // tokens caused by one byte, packed to the front, in output order
  typedef struct packed {
    logic [1:0]          count;
    token_t [MaxToks-1:0] tok;
  } lex_res_t;

  function automatic logic is_digit(logic [ByteBits-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_alpha(logic [ByteBits-1:0] c);
    return ((c >= CH_LC_A) && (c <= CH_LC_Z)) || ((c >= CH_UC_A) && (c <= CH_UC_Z));
  endfunction

  function automatic logic is_word(logic [ByteBits-1:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
  endfunction

  function automatic logic is_space(logic [ByteBits-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic [PosBits-1:0] sat_inc(logic [PosBits-1:0] p);
    return (p == PosMax) ? p : p + 1'b1;
  endfunction

  // length from token begin to end_pos, zero if not past begin, saturating
  function automatic logic [LenBits-1:0] span_len(logic [PosBits-1:0] end_pos,
                                                  logic [PosBits-1:0] beg_pos);
    logic [PosBits-1:0] diff;
    diff = end_pos - beg_pos;
    if (end_pos <= beg_pos) return '0;
    if ((PosBits > LenBits) && ((diff >> LenBits) != '0)) return '1;
    return LenBits'(diff);
  endfunction

endpackage

@@ rtl/core/sbt_byte_if.sv @@
// ----------------------------------------------------------------------------
// sbt_byte_if
// Source byte channel: valid/ready with one byte per beat.
// ----------------------------------------------------------------------------
interface sbt_byte_if;
  import sbt_pkg::*;

  logic                valid;
  logic                ready;
  logic [ByteBits-1:0] source_byte;

  modport source (output valid, output source_byte, input ready);
  modport sink   (input valid, input source_byte, output ready);
endinterface

@@ rtl/core/sbt_token_if.sv @@
// ----------------------------------------------------------------------------
// sbt_token_if
// Token channel: valid/ready with one token per beat.
// ----------------------------------------------------------------------------
interface sbt_token_if;
  import sbt_pkg::*;

  logic                valid;
  logic                ready;
  logic [KindBits-1:0] token_kind;
  logic [LenBits-1:0]  token_start;
  logic [LenBits-1:0]  token_length;
  logic                last_of_run;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input token_start,
                  input token_length, input last_of_run, output ready);
endinterface

@@ rtl/core/sbt_lexer.sv @@
// ----------------------------------------------------------------------------
// sbt_lexer
// Lexing state and per-byte decode: mode, position and token begin update on
// each accepted byte; the tokens that byte completes are produced alongside.
// ----------------------------------------------------------------------------
module sbt_lexer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [sbt_pkg::ByteBits-1:0]  byte_i,
  output sbt_pkg::lex_res_t             res_o
);
  import sbt_pkg::*;

  lex_mode_e          mode_q, mode_d;
  logic [PosBits-1:0] pos_q, pos_d;
  logic [PosBits-1:0] begin_q, begin_d;

  logic               taken;
  logic               flush_vld;
  token_kind_e        flush_kind;
  logic [PosBits-1:0] flush_end;
  logic               dot_vld;
  logic [PosBits-1:0] dot_pos;
  lex_mode_e          mode_mid;

  logic               fresh_vld;
  token_kind_e        fresh_kind;
  logic               fresh_len1;

  token_t [MaxToks-1:0] cand;
  logic   [MaxToks-1:0] cand_vld;

  assign dot_pos = (pos_q != '0) ? pos_q - 1'b1 : '0;

  // pending token: continue it or close it
  always_comb begin
    taken      = 1'b0;
    flush_vld  = 1'b0;
    flush_kind = TK_END;
    flush_end  = pos_q;
    dot_vld    = 1'b0;
    mode_mid   = MODE_IDLE;
    unique case (mode_q)
      MODE_STR: begin
        flush_kind = TK_STRING;
        if (byte_i == CH_QUOTE) begin
          flush_vld = 1'b1;
          taken     = 1'b1;
        end else if (byte_i == CH_NUL) begin
          flush_vld = 1'b1;
        end else begin
          taken    = 1'b1;
          mode_mid = MODE_STR;
        end
      end
      MODE_INT: begin
        flush_kind = TK_INT;
        if (is_digit(byte_i)) begin
          taken    = 1'b1;
          mode_mid = MODE_INT;
        end else if (byte_i == CH_DOT) begin
          taken    = 1'b1;
          mode_mid = MODE_INTDOT;
        end else begin
          flush_vld = 1'b1;
        end
      end
      MODE_INTDOT: begin
        flush_kind = TK_INT;
        if (is_digit(byte_i)) begin
          taken    = 1'b1;
          mode_mid = MODE_FLOAT;
        end else begin
          // integer ends before the dot, the dot itself is an unknown byte
          flush_vld = 1'b1;
          flush_end = dot_pos;
          dot_vld   = 1'b1;
        end
      end
      MODE_FLOAT: begin
        flush_kind = TK_FLOAT;
        if (is_digit(byte_i)) begin
          taken    = 1'b1;
          mode_mid = MODE_FLOAT;
        end else begin
          flush_vld = 1'b1;
        end
      end
      MODE_IDENT: begin
        flush_kind = TK_IDENT;
        if (is_word(byte_i)) begin
          taken    = 1'b1;
          mode_mid = MODE_IDENT;
        end else begin
          flush_vld = 1'b1;
        end
      end
      default: begin
        mode_mid = MODE_IDLE;
      end
    endcase
  end

  // byte not absorbed by a pending token is lexed from idle
  always_comb begin
    fresh_vld  = 1'b0;
    fresh_kind = TK_END;
    fresh_len1 = 1'b0;
    if (!taken) begin
      if (byte_i == CH_NUL) begin
        fresh_vld = 1'b1;
      end else if (!is_space(byte_i) && !is_digit(byte_i) && !is_alpha(byte_i)) begin
        fresh_vld  = 1'b1;
        fresh_len1 = 1'b1;
        case (byte_i) inside
          CH_LPAREN: fresh_kind = TK_LPAREN;
          CH_RPAREN: fresh_kind = TK_RPAREN;
          CH_SEMI:   fresh_kind = TK_SEMI;
          CH_EQUALS: fresh_kind = TK_EQUALS;
          CH_COLON:  fresh_kind = TK_COLON;
          CH_QUOTE, CH_UNDER: begin
            fresh_vld  = 1'b0;
            fresh_len1 = 1'b0;
          end
          default: begin
            fresh_kind = TK_END;
            fresh_len1 = 1'b0;
          end
        endcase
      end
    end
  end

  // next state
  always_comb begin
    mode_d  = mode_mid;
    begin_d = begin_q;
    pos_d   = sat_inc(pos_q);
    if (!taken) begin
      if (byte_i == CH_QUOTE) begin
        mode_d  = MODE_STR;
        begin_d = sat_inc(pos_q);
      end else if (is_digit(byte_i)) begin
        mode_d  = MODE_INT;
        begin_d = pos_q;
      end else if (is_alpha(byte_i) || (byte_i == CH_UNDER)) begin
        mode_d  = MODE_IDENT;
        begin_d = pos_q;
      end
    end
    if (byte_i == CH_NUL) begin
      mode_d  = MODE_IDLE;
      begin_d = '0;
      pos_d   = '0;
    end
  end

  // candidate tokens in order, then packed to the front
  always_comb begin
    logic [1:0] idx;
    cand[0].kind   = flush_kind;
    cand[0].start  = LenBits'(begin_q);
    cand[0].length = span_len(flush_end, begin_q);
    cand[1].kind   = TK_END;
    cand[1].start  = LenBits'(dot_pos);
    cand[1].length = '0;
    cand[2].kind   = fresh_kind;
    cand[2].start  = LenBits'(pos_q);
    cand[2].length = LenBits'(fresh_len1);
    cand_vld       = {fresh_vld, dot_vld, flush_vld};

    idx       = '0;
    res_o.tok = '0;
    for (int i = 0; i < MaxToks; i++) begin
      if (cand_vld[i]) begin
        res_o.tok[idx] = cand[i];
        idx            = idx + 1'b1;
      end
    end
    res_o.count = idx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      pos_q   <= '0;
      begin_q <= '0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      begin_q <= begin_d;
    end
  end

endmodule

@@ rtl/core/source_byte_tokenizer_unit.sv @@
// ----------------------------------------------------------------------------
// source_byte_tokenizer_unit
// Streaming tokenizer: one source byte per beat in, one token per beat out.
// ----------------------------------------------------------------------------
// Output: a token is offered in the cycle after the byte that completes it.
// Throughput: one byte per cycle while tokens are taken; a byte that
//   completes two or three tokens holds the input while the queue drains.
// Reset: mode idle, position and token begin zero, token queue empty.
module source_byte_tokenizer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  sbt_byte_if.sink    byte_i,
  sbt_token_if.source token_o
);
  import sbt_pkg::*;

  lex_res_t             lex_res;
  logic                 in_beat;
  logic                 out_beat;
  token_t [MaxToks-1:0] tok_q;
  logic [1:0]           cnt_q;

  assign out_beat     = token_o.valid && token_o.ready;
  // take a new byte once the queue is empty or its last token leaves now
  assign byte_i.ready = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && token_o.ready);
  assign in_beat      = byte_i.valid && byte_i.ready;

  sbt_lexer u_lexer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_beat),
    .byte_i   (byte_i.source_byte),
    .res_o    (lex_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_beat) begin
      cnt_q <= lex_res.count;
    end else if (out_beat) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      tok_q <= lex_res.tok;
    end else if (out_beat) begin
      tok_q[0] <= tok_q[1];
      tok_q[1] <= tok_q[2];
    end
  end

  assign token_o.valid        = (cnt_q != 2'd0);
  assign token_o.token_kind   = tok_q[0].kind;
  assign token_o.token_start  = tok_q[0].start;
  assign token_o.token_length = tok_q[0].length;
  assign token_o.last_of_run  = (cnt_q == 2'd1);

endmodule
